[rtl/polynomial_multiplier_core_macros.svh]
// assertion helpers for the polynomial multiplier core
`ifndef POLYNOMIAL_MULTIPLIER_CORE_MACROS_SVH
`define POLYNOMIAL_MULTIPLIER_CORE_MACROS_SVH

// same-cycle implication
`define PMUL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMUL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pmul_pkg.sv]
package pmul_pkg;

    localparam int DATA_W          = 32;
    localparam int POWER_IDX_W     = 5;
    localparam int PRODUCT_POWER_W = 6;
    localparam int DEGREE_W        = 5;
    localparam int FUNC_W          = 2;
    localparam int CFG_INDEX_W     = 1;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A   = 2'd0,
        FUNC_LOAD_B   = 2'd1,
        FUNC_MULTIPLY = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEGREE_A = 1'd0,
        REG_DEGREE_B = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                   adv;
        logic                   load_a;
        logic [POWER_IDX_W-1:0] load_idx;
    } pmul_ctrl_t;

endpackage

[rtl/pmul_cell.sv]
module pmul_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       load,
    input  logic [pmul_pkg::DATA_W-1:0] load_data,
    input  logic                       active,
    input  logic [pmul_pkg::DATA_W-1:0] x_in,
    input  logic [pmul_pkg::DATA_W-1:0] sum_in,
    output logic [pmul_pkg::DATA_W-1:0] sum_out
);
    import pmul_pkg::*;

    logic [DATA_W-1:0] coef_reg;
    logic [DATA_W-1:0] coef_next;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] prod_next;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] sum_next;
    logic [DATA_W-1:0] mul_lo;

    // only the low word of the product is kept
    assign mul_lo    = coef_reg * x_in;
    assign coef_next = load ? load_data : coef_reg;
    assign prod_next = adv ? (active ? mul_lo : '0) : prod_reg;
    assign sum_next  = adv ? (prod_reg + sum_in) : sum_reg;
    assign sum_out   = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            prod_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

[rtl/pmul_chain.sv]
module pmul_chain #(
    parameter int MAX_DEGREE = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmul_pkg::pmul_ctrl_t          ctrl,
    input  logic [pmul_pkg::DATA_W-1:0]   load_data,
    input  logic [pmul_pkg::DEGREE_W-1:0] degree_a,
    input  logic [pmul_pkg::DATA_W-1:0]   x_in,
    output logic [pmul_pkg::DATA_W-1:0]   sum_out
);
    import pmul_pkg::*;

    localparam int CELLS = MAX_DEGREE + 1;

    logic [DATA_W-1:0] link [CELLS+1];

    assign link[CELLS] = '0;
    assign sum_out     = link[0];

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        pmul_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (ctrl.adv),
            .load      (ctrl.load_a && (ctrl.load_idx == POWER_IDX_W'(i))),
            .load_data (load_data),
            .active    (DEGREE_W'(i) <= degree_a),
            .x_in      (x_in),
            .sum_in    (link[i+1]),
            .sum_out   (link[i])
        );
    end

endmodule

[rtl/polynomial_multiplier_core.sv]
// polynomial multiplier, a row of multiply-accumulate cells in transposed form
// input stream: tuser carries the function, tdata the power and coefficient
//   load A writes the cell of that power, load B writes the feed store,
//   a load gives no output transaction
// multiply: B is fed one coefficient a cycle into the row unless the output
//   stalls, every cell adds its product to the partial sum of its neighbor,
//   cell 0 yields terms in order from power 0; one term per cycle while the
//   output is not stalled, tlast on the highest power
// a multiply holds the input stream until its last term is emitted; the row
//   has three pipeline steps: feed register, cell product and row sum
// configuration channel is always ready, a degree above MAX_DEGREE saturates
// receiver stall: the whole row freezes until the output register drains
// reset clears degrees, A cells, row sums and control; coefficients must be
//   loaded before a multiply reads them
module polynomial_multiplier_core #(
    parameter int MAX_DEGREE = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // power_index [4:0], coefficient [36:5], zero fill
    input  logic [pmul_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func [1:0]
    input  logic [pmul_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // product_power [5:0], product_coefficient [37:6], zero fill
    output logic [pmul_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmul_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmul_pkg::DEGREE_W-1:0]    cfg_data
);
    import pmul_pkg::*;

    `include "polynomial_multiplier_core_macros.svh"

    localparam int IDX_W = (MAX_DEGREE < 1) ? 1 : $clog2(MAX_DEGREE + 1);
    localparam int CNT_W = $clog2(2 * MAX_DEGREE + 4);
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int LAT   = 3;

    logic [DEGREE_W-1:0]        degree_a_reg;
    logic [DEGREE_W-1:0]        degree_a_next;
    logic [DEGREE_W-1:0]        degree_b_reg;
    logic [DEGREE_W-1:0]        degree_b_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [DATA_W-1:0]          x_reg;
    logic [DATA_W-1:0]          x_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [PRODUCT_POWER_W-1:0] m_power_reg;
    logic [PRODUCT_POWER_W-1:0] m_power_next;
    logic [DATA_W-1:0]          m_coef_reg;
    logic [DATA_W-1:0]          m_coef_next;
    logic                       m_last_reg;
    logic                       m_last_next;
    logic [DATA_W-1:0]          b_mem [DEPTH];

    logic [POWER_IDX_W-1:0]     in_power;
    logic [DATA_W-1:0]          in_coef;
    func_t                      in_func;
    logic                       in_acc;
    logic                       idx_ok;
    logic                       load_b;
    logic                       mult_acc;
    logic                       out_free;
    logic                       adv;
    logic                       emit;
    logic                       last_emit;
    logic [PRODUCT_POWER_W-1:0] top_power;
    logic [CNT_W-1:0]           last_cnt;
    logic [DEGREE_W-1:0]        cfg_clamped;
    logic [DATA_W-1:0]          row_sum;
    pmul_ctrl_t                 ctrl;

    assign in_power = s_axis_tdata[POWER_IDX_W-1:0];
    assign in_coef  = s_axis_tdata[POWER_IDX_W+DATA_W-1:POWER_IDX_W];
    assign in_func  = func_t'(s_axis_tuser);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign idx_ok   = in_power <= POWER_IDX_W'(MAX_DEGREE);
    assign load_b   = in_acc && (in_func == FUNC_LOAD_B) && idx_ok;
    assign mult_acc = in_acc && (in_func == FUNC_MULTIPLY);

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign adv       = !busy_reg || out_free;
    assign top_power = PRODUCT_POWER_W'(degree_a_reg) + PRODUCT_POWER_W'(degree_b_reg);
    assign last_cnt  = CNT_W'(top_power) + CNT_W'(LAT);
    assign emit      = busy_reg && out_free && (cnt_reg >= CNT_W'(LAT));
    assign last_emit = emit && (cnt_reg == last_cnt);

    assign ctrl.adv      = adv;
    assign ctrl.load_a   = in_acc && (in_func == FUNC_LOAD_A) && idx_ok;
    assign ctrl.load_idx = in_power;

    pmul_chain #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_data (in_coef),
        .degree_a  (degree_a_reg),
        .x_in      (x_reg),
        .sum_out   (row_sum)
    );

    assign cfg_clamped = (cfg_data > DEGREE_W'(MAX_DEGREE)) ? DEGREE_W'(MAX_DEGREE) : cfg_data;

    always_comb
    begin
        degree_a_next = degree_a_reg;
        degree_b_next = degree_b_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEGREE_A: degree_a_next = cfg_clamped;
                REG_DEGREE_B: degree_b_next = cfg_clamped;
                default:      degree_a_next = degree_a_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (mult_acc)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (last_emit)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && adv)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        x_next = x_reg;
        if (adv)
        begin
            if (busy_reg && (cnt_reg <= CNT_W'(degree_b_reg)))
                x_next = b_mem[cnt_reg[IDX_W-1:0]];
            else
                x_next = '0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_power_next = m_power_reg;
        m_coef_next  = m_coef_reg;
        m_last_next  = m_last_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_power_next = PRODUCT_POWER_W'(cnt_reg - CNT_W'(LAT));
            m_coef_next  = row_sum;
            m_last_next  = last_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
            b_mem[in_power[IDX_W-1:0]] <= in_coef;
    end

    always_ff @(posedge clk)
    begin
        m_power_reg <= m_power_next;
        m_coef_reg  <= m_coef_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_a_reg <= '0;
            degree_b_reg <= '0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            x_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            degree_a_reg <= degree_a_next;
            degree_b_reg <= degree_b_next;
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            x_reg        <= x_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign s_axis_tready = !busy_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {
        (M_TDATA_W - PRODUCT_POWER_W - DATA_W)'(0),
        m_coef_reg,
        m_power_reg
    };

    `PMUL_ASSERT_NEXT(a_mult_starts, clk, rst_n, mult_acc,
        busy_reg && (cnt_reg == '0), "multiply did not start the sequencer")
    `PMUL_ASSERT_NEXT(a_stall_holds, clk, rst_n, busy_reg && m_valid_reg && !m_axis_tready,
        $stable(cnt_reg) && $stable(x_reg), "sequencer moved while output stalled")
    `PMUL_ASSERT_NEXT(a_last_ends, clk, rst_n, last_emit,
        !busy_reg && m_valid_reg && m_axis_tlast, "last term did not end the multiply")

endmodule
